// File: rtl/lcq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the line set maximum query block.
// No dependencies.
package lcq_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic signed [63:0] EMPTY_VALUE = -64'sd2000000000000000000;
  localparam logic signed [61:0] EMPTY_ICPT  = EMPTY_VALUE[61:0];

  typedef logic signed [31:0] coord_t;
  typedef logic signed [31:0] slope_t;
  typedef logic signed [61:0] icpt_t;
  typedef logic signed [63:0] value_t;

  typedef struct packed {
    slope_t slope;
    icpt_t  icpt;
  } node_line_t;

endpackage
`default_nettype wire

// File: rtl/lcq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Request channel of the line set maximum query block.
// Depends on lcq_pkg.
interface lcq_in_if
  import lcq_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  coord_index;
  coord_t      coord_value;
  slope_t      slope;
  icpt_t       intercept;
  modport source (output valid, action, coord_index, coord_value, slope, intercept,
                  input ready);
  modport sink (input valid, action, coord_index, coord_value, slope, intercept,
                output ready);
endinterface
`default_nettype wire

// File: rtl/lcq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the line set maximum query block.
// Depends on lcq_pkg.
interface lcq_out_if
  import lcq_pkg::*;
  ();
  logic   valid;
  logic   ready;
  value_t max_value;
  logic   out_of_range;
  modport source (output valid, max_value, out_of_range, input ready);
  modport sink (input valid, max_value, out_of_range, output ready);
endinterface
`default_nettype wire

// File: rtl/lcq_coord_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// Coordinate table: one write port, one registered read port.
// Depends on lcq_pkg.
module lcq_coord_mem
  import lcq_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire coord_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output coord_t             rdata
);

  coord_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/lcq_node_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// Tree node store holding one line per node, registered read.
// Depends on lcq_pkg.
module lcq_node_mem
  import lcq_pkg::*;
#(
  parameter int DEPTH = 2047,
  parameter int NW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [NW-1:0] waddr,
  input  wire node_line_t    wdata,
  input  wire logic [NW-1:0] raddr,
  output node_line_t         rdata
);

  node_line_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/lcq_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencer for loads, line inserts and queries over the two memories.
// Depends on lcq_pkg and the channel interfaces.
module lcq_engine
  import lcq_pkg::*;
#(
  parameter int TABLE_SIZE = 1024,
  parameter int AW = 10,
  parameter int LEAVES = 1024,
  parameter int NODES = 2047,
  parameter int NW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [10:0]   cfg_wr_data,
  lcq_in_if.sink             in_ch,
  lcq_out_if.source          out_ch,
  output logic               coord_we,
  output logic [AW-1:0]      coord_waddr,
  output coord_t             coord_wdata,
  output logic [AW-1:0]      coord_raddr,
  input  wire coord_t        coord_q,
  output logic               node_we,
  output logic [NW-1:0]      node_waddr,
  output node_line_t         node_wdata,
  output logic [NW-1:0]      node_raddr,
  input  wire node_line_t    node_q
);

  localparam int PW = AW + 1;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] A_RD0   = 5'd2;
  localparam logic [4:0] A_RD1   = 5'd3;
  localparam logic [4:0] A_RD2   = 5'd4;
  localparam logic [4:0] A_RD3   = 5'd5;
  localparam logic [4:0] A_EV    = 5'd6;
  localparam logic [4:0] A_DEC   = 5'd7;
  localparam logic [4:0] Q_SRD   = 5'd8;
  localparam logic [4:0] Q_SCMP  = 5'd9;
  localparam logic [4:0] Q_LAST  = 5'd10;
  localparam logic [4:0] Q_NRD   = 5'd11;
  localparam logic [4:0] Q_NLAT  = 5'd12;
  localparam logic [4:0] Q_MUL   = 5'd13;
  localparam logic [4:0] Q_ADD   = 5'd14;
  localparam logic [4:0] Q_OUT   = 5'd15;

  logic [4:0]    state_r, state_nxt;
  logic [10:0]   count_r;
  logic [NW-1:0] clr_r, clr_nxt;
  logic [NW-1:0] node_r, node_nxt;
  logic [PW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, n_r, n_nxt;
  logic [NW-1:0] p_r, p_nxt;
  logic [2:0]    k_r, k_nxt;
  coord_t        x_r, x_nxt, xl_r, xr_r, xm_r;
  slope_t        a_r, a_nxt, cs_r;
  icpt_t         b_r, b_nxt, ci_r;
  value_t        prod_r, pb_r, best_r, best_nxt;
  value_t        ev_r [6];
  value_t        res_max_r, res_max_nxt;
  logic          res_oor_r, res_oor_nxt;
  logic          out_val_r, out_val_nxt;
  value_t        out_max_r;
  logic          out_oor_r;

  logic [AW-1:0] last_w;
  logic [PW:0]   mid_sum_w;
  logic [PW-1:0] mid_w, half_w;
  slope_t        mul_a;
  coord_t        mul_x;
  icpt_t         mul_b;
  value_t        mul_w, sum_w;
  value_t        na, ca, nb, cb, na2, ca2, nb2, cb2;
  logic          sw;

  function automatic logic [AW-1:0] clamp_pos(input logic [PW-1:0] pos,
                                              input logic [AW-1:0] last);
    logic [AW-1:0] r;
    if (32'(pos) > 32'(last)) begin
      r = last;
    end else begin
      r = pos[AW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    if (count_r == 11'd0) begin
      last_w = '0;
    end else if (32'(count_r) > TABLE_SIZE) begin
      last_w = AW'(TABLE_SIZE - 1);
    end else begin
      last_w = AW'(count_r - 11'd1);
    end
  end

  assign mid_sum_w = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w     = mid_sum_w[PW:1];
  assign half_w    = n_r >> 1;

  always_comb begin
    mul_a = cs_r;
    mul_b = ci_r;
    mul_x = x_r;
    if (state_r == A_EV) begin
      mul_a = k_r[0] ? cs_r : a_r;
      mul_b = k_r[0] ? ci_r : b_r;
      case (k_r[2:1])
        2'd0:    mul_x = xl_r;
        2'd1:    mul_x = xr_r;
        default: mul_x = xm_r;
      endcase
    end
  end

  assign mul_w = mul_a * mul_x;
  assign sum_w = prod_r + pb_r;

  assign na  = ev_r[0];
  assign ca  = ev_r[1];
  assign nb  = ev_r[2];
  assign cb  = ev_r[3];
  assign sw  = ev_r[4] > ev_r[5];
  assign na2 = sw ? ca : na;
  assign ca2 = sw ? na : ca;
  assign nb2 = sw ? cb : nb;
  assign cb2 = sw ? nb : cb;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    node_nxt    = node_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    n_nxt       = n_r;
    p_nxt       = p_r;
    k_nxt       = k_r;
    x_nxt       = x_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    best_nxt    = best_r;
    res_max_nxt = res_max_r;
    res_oor_nxt = res_oor_r;
    out_val_nxt = out_val_r && !out_ch.ready;
    coord_we    = 1'b0;
    coord_waddr = AW'(in_ch.coord_index);
    coord_wdata = in_ch.coord_value;
    coord_raddr = clamp_pos(lo_r, last_w);
    node_we     = 1'b0;
    node_waddr  = node_r;
    node_wdata  = '{slope: a_r, icpt: b_r};
    node_raddr  = node_r;
    unique case (state_r)
      S_CLR: begin
        node_we    = 1'b1;
        node_waddr = clr_r;
        node_wdata = '{slope: '0, icpt: EMPTY_ICPT};
        clr_nxt    = clr_r + NW'(1);
        if (clr_r == NW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.action)
            ACT_LOAD: begin
              coord_we = 32'(in_ch.coord_index) < TABLE_SIZE;
            end
            ACT_ADD: begin
              a_nxt     = in_ch.slope;
              b_nxt     = in_ch.intercept;
              node_nxt  = '0;
              lo_nxt    = '0;
              hi_nxt    = PW'(LEAVES);
              state_nxt = A_RD0;
            end
            ACT_QUERY: begin
              x_nxt     = in_ch.coord_value;
              lo_nxt    = '0;
              n_nxt     = PW'(LEAVES);
              best_nxt  = {1'b1, 63'd0};
              state_nxt = Q_SRD;
            end
            default: begin
            end
          endcase
        end
      end
      A_RD0: begin
        coord_raddr = clamp_pos(lo_r, last_w);
        state_nxt   = A_RD1;
      end
      A_RD1: begin
        coord_raddr = clamp_pos(hi_r - PW'(1), last_w);
        state_nxt   = A_RD2;
      end
      A_RD2: begin
        coord_raddr = clamp_pos(mid_w, last_w);
        state_nxt   = A_RD3;
      end
      A_RD3: begin
        k_nxt     = '0;
        state_nxt = A_EV;
      end
      A_EV: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd6) begin
          state_nxt = A_DEC;
        end
      end
      A_DEC: begin
        state_nxt = S_IDLE;
        if (na <= ca && nb <= cb) begin
          state_nxt = S_IDLE;
        end else if (na >= ca && nb >= cb) begin
          node_we = 1'b1;
        end else if (hi_r - lo_r < PW'(2)) begin
          state_nxt = S_IDLE;
        end else begin
          if (sw) begin
            node_we = 1'b1;
            a_nxt   = cs_r;
            b_nxt   = ci_r;
          end
          if (na2 > ca2) begin
            node_nxt  = {node_r[NW-2:0], 1'b1};
            hi_nxt    = mid_w;
            state_nxt = A_RD0;
          end else if (nb2 > cb2) begin
            node_nxt  = {node_r[NW-2:0], 1'b0} + NW'(2);
            lo_nxt    = mid_w;
            state_nxt = A_RD0;
          end
        end
      end
      Q_SRD: begin
        if (n_r == '0) begin
          coord_raddr = last_w;
          state_nxt   = Q_LAST;
        end else begin
          coord_raddr = clamp_pos(lo_r + half_w, last_w);
          state_nxt   = Q_SCMP;
        end
      end
      Q_SCMP: begin
        if (coord_q < x_r) begin
          lo_nxt = lo_r + half_w + PW'(1);
          n_nxt  = n_r - half_w - PW'(1);
        end else begin
          n_nxt = half_w;
        end
        state_nxt = Q_SRD;
      end
      Q_LAST: begin
        if (x_r > coord_q || 32'(lo_r) >= LEAVES) begin
          res_max_nxt = '0;
          res_oor_nxt = 1'b1;
          state_nxt   = Q_OUT;
        end else begin
          p_nxt     = NW'(lo_r) + NW'(LEAVES - 1);
          state_nxt = Q_NRD;
        end
      end
      Q_NRD: begin
        node_raddr = p_r;
        state_nxt  = Q_NLAT;
      end
      Q_NLAT: begin
        state_nxt = Q_MUL;
      end
      Q_MUL: begin
        state_nxt = Q_ADD;
      end
      Q_ADD: begin
        if (sum_w > best_r) begin
          best_nxt = sum_w;
        end
        if (p_r == '0) begin
          res_max_nxt = (best_nxt < EMPTY_VALUE) ? EMPTY_VALUE : best_nxt;
          res_oor_nxt = 1'b0;
          state_nxt   = Q_OUT;
        end else begin
          p_nxt     = (p_r - NW'(1)) >> 1;
          state_nxt = Q_NRD;
        end
      end
      Q_OUT: begin
        if (!out_val_r || out_ch.ready) begin
          out_val_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      count_r   <= 11'd1;
      out_val_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      out_val_r <= out_val_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    n_r       <= n_nxt;
    p_r       <= p_nxt;
    k_r       <= k_nxt;
    x_r       <= x_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    best_r    <= best_nxt;
    res_max_r <= res_max_nxt;
    res_oor_r <= res_oor_nxt;
    prod_r    <= mul_w;
    pb_r      <= {{2{mul_b[61]}}, mul_b};
    if (state_r == A_RD1) begin
      xl_r <= coord_q;
      cs_r <= node_q.slope;
      ci_r <= node_q.icpt;
    end
    if (state_r == Q_NLAT) begin
      cs_r <= node_q.slope;
      ci_r <= node_q.icpt;
    end
    if (state_r == A_RD2) begin
      xr_r <= coord_q;
    end
    if (state_r == A_RD3) begin
      xm_r <= coord_q;
    end
    if (state_r == A_EV && k_r != 3'd0) begin
      ev_r[k_r - 3'd1] <= sum_w;
    end
    if (state_r == Q_OUT && (!out_val_r || out_ch.ready)) begin
      out_max_r <= res_max_r;
      out_oor_r <= res_oor_r;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_val_r;
  assign out_ch.max_value    = out_max_r;
  assign out_ch.out_of_range = out_oor_r;

  a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == Q_SRD || state_r == Q_SCMP || state_r == Q_LAST || state_r == Q_NRD ||
     state_r == Q_ADD) |-> !node_we)
    else $error("node store written during a query");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && clr_r == NW'(NODES - 1)) |=> state_r == S_IDLE)
    else $error("clearing sweep did not end");

  a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == Q_SCMP |-> n_r != '0)
    else $error("search step with empty range");

  a_lo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == Q_SRD |-> 32'(lo_r) + 32'(n_r) <= LEAVES)
    else $error("search range beyond leaves");

endmodule
`default_nettype wire

// File: rtl/line_set_max_query_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Keeps a set of lines in a segment tree over a loaded coordinate table and
// answers maximum queries. An add makes four reads and seven steps of the
// shared multiplier per tree level, and a query runs a binary search on the
// coordinate memory (a read and a compare per step) and then a node read,
// latch, multiply and add per tree level from the node memory. After reset
// a clearing pass writes all 2*leaves-1 nodes of the node memory before the
// first request is accepted.
module line_set_max_query_top
  import lcq_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data,
  lcq_in_if.sink           in_ch,
  lcq_out_if.source        out_ch
);

  localparam int AW     = $clog2(TABLE_SIZE);
  localparam int LEAVES = 1 << AW;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int NW     = AW + 1;

  logic          coord_we;
  logic [AW-1:0] coord_waddr, coord_raddr;
  coord_t        coord_wdata, coord_q;
  logic          node_we;
  logic [NW-1:0] node_waddr, node_raddr;
  node_line_t    node_wdata, node_q;

  lcq_coord_mem #(.DEPTH(TABLE_SIZE), .AW(AW)) u_coord (
    .clk(clk), .we(coord_we), .waddr(coord_waddr), .wdata(coord_wdata),
    .raddr(coord_raddr), .rdata(coord_q)
  );

  lcq_node_mem #(.DEPTH(NODES), .NW(NW)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_q)
  );

  lcq_engine #(
    .TABLE_SIZE(TABLE_SIZE), .AW(AW), .LEAVES(LEAVES), .NODES(NODES), .NW(NW)
  ) u_engine (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch), .out_ch(out_ch),
    .coord_we(coord_we), .coord_waddr(coord_waddr), .coord_wdata(coord_wdata),
    .coord_raddr(coord_raddr), .coord_q(coord_q),
    .node_we(node_we), .node_waddr(node_waddr), .node_wdata(node_wdata),
    .node_raddr(node_raddr), .node_q(node_q)
  );

endmodule
`default_nettype wire
